// File: rtl/sme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sme_pkg - shared types and constants
// Opcodes, status codes, widths and the control/status structs that join
// the controller and the datapath of the stack machine execute unit.
// ----------------------------------------------------------------------------
package sme_pkg;

  localparam int CODE_WORDS  = 4096;
  localparam int DATA_WORDS  = 1024;
  localparam int FRAME_WORDS = 3;
  localparam int PC_W        = $clog2(CODE_WORDS);
  localparam int AW          = $clog2(DATA_WORDS);
  localparam int SP_W        = AW + 1;
  localparam int WORD_W      = 64;
  localparam int CMD_W       = 5;
  localparam int CNT_W       = 8;
  localparam int ST_W        = 3;

  typedef logic [CMD_W-1:0] opcode_t;
  localparam opcode_t OP_CONST = 5'd0;
  localparam opcode_t OP_LDC   = 5'd1;
  localparam opcode_t OP_LDI   = 5'd2;
  localparam opcode_t OP_PUSH  = 5'd3;
  localparam opcode_t OP_POP   = 5'd4;
  localparam opcode_t OP_JMP   = 5'd5;
  localparam opcode_t OP_JZ    = 5'd6;
  localparam opcode_t OP_JNZ   = 5'd7;
  localparam opcode_t OP_CALL  = 5'd8;
  localparam opcode_t OP_RET   = 5'd9;
  localparam opcode_t OP_LDARG = 5'd10;
  localparam opcode_t OP_OR    = 5'd11;
  localparam opcode_t OP_AND   = 5'd12;
  localparam opcode_t OP_EQ    = 5'd13;
  localparam opcode_t OP_NE    = 5'd14;
  localparam opcode_t OP_GT    = 5'd15;
  localparam opcode_t OP_GE    = 5'd16;
  localparam opcode_t OP_LT    = 5'd17;
  localparam opcode_t OP_LE    = 5'd18;
  localparam opcode_t OP_SHR   = 5'd19;
  localparam opcode_t OP_SHL   = 5'd20;
  localparam opcode_t OP_ADD   = 5'd21;
  localparam opcode_t OP_SUB   = 5'd22;
  localparam opcode_t OP_MUL   = 5'd23;
  localparam opcode_t OP_DIV   = 5'd24;
  localparam opcode_t OP_MOD   = 5'd25;
  localparam opcode_t OP_NOP   = 5'd26;
  localparam opcode_t OP_EXIT  = 5'd27;

  typedef logic [ST_W-1:0] status_t;
  localparam status_t ST_RUN   = 3'd0;
  localparam status_t ST_EXIT  = 3'd1;
  localparam status_t ST_BADOP = 3'd2;
  localparam status_t ST_DIVZ  = 3'd3;
  localparam status_t ST_STACK = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic       clr_step;
    logic       load_instr;
    logic       rd_en;
    logic       cap_en;
    logic       wr_en;
    logic       md_start;
    logic       commit;
    logic [1:0] phase;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       clr_done;
    logic       halted;
    logic       pre_err;
    logic [1:0] n_reads;
    logic [1:0] n_writes;
    logic       need_md;
    logic       md_done;
    logic       out_free;
  } dp_stat_t;

endpackage

// File: rtl/sme_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sme_if - instruction and result channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sme_in_if import sme_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [WORD_W-1:0] immediate;
  logic [CNT_W-1:0]  arg_count;

  modport source (output valid, command, immediate, arg_count, input ready);
  modport sink   (input valid, command, immediate, arg_count, output ready);
endinterface

interface sme_out_if import sme_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PC_W-1:0]   next_pc;
  logic [WORD_W-1:0] accumulator;
  logic [SP_W-1:0]   stack_pointer;
  logic [ST_W-1:0]   status;

  modport source (output valid, next_pc, accumulator, stack_pointer, status, input ready);
  modport sink   (input valid, next_pc, accumulator, stack_pointer, status, output ready);
endinterface

// File: rtl/sme_md.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sme_md - iterative multiply / divide unit
// One bit per cycle: shift-add multiply or restoring unsigned divide, 64 steps.
// ----------------------------------------------------------------------------
module sme_md import sme_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              is_mul,
  input  logic [WORD_W-1:0] a_in,   // multiplicand / divisor
  input  logic [WORD_W-1:0] b_in,   // multiplier / dividend
  output logic              done,
  output logic [WORD_W-1:0] prod,
  output logic [WORD_W-1:0] quo,
  output logic [WORD_W-1:0] rem
);

  localparam int CW = $clog2(WORD_W);

  logic              busy_r, done_r, mul_r;
  logic [CW-1:0]     cnt_r;
  logic [WORD_W-1:0] a_r, b_r, p_r;
  logic [WORD_W-1:0] shl_rem;
  logic              ge;

  assign shl_rem = {p_r[WORD_W-2:0], b_r[WORD_W-1]};
  assign ge      = (shl_rem >= a_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(WORD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mul_r <= is_mul;
      a_r   <= a_in;
      b_r   <= b_in;
      p_r   <= '0;
    end else if (busy_r) begin
      if (mul_r) begin
        p_r <= p_r + (b_r[0] ? a_r : '0);
        a_r <= {a_r[WORD_W-2:0], 1'b0};
        b_r <= {1'b0, b_r[WORD_W-1:1]};
      end else begin
        p_r <= ge ? (shl_rem - a_r) : shl_rem;
        b_r <= {b_r[WORD_W-2:0], ge};
      end
    end
  end

  assign done = done_r;
  assign prod = p_r;
  assign quo  = b_r;
  assign rem  = p_r;

endmodule

// File: rtl/sme_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sme_dp - execute datapath
// Architectural registers, stack/data memory, ALU, fault checks, result reg.
// ----------------------------------------------------------------------------
module sme_dp import sme_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ctrl_cmd_t         cmd,
  output dp_stat_t          stat,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [WORD_W-1:0] in_immediate,
  input  logic [CNT_W-1:0]  in_arg_count,
  input  logic              cfg_we,
  input  logic [PC_W-1:0]   cfg_data,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [PC_W-1:0]   out_next_pc,
  output logic [WORD_W-1:0] out_accumulator,
  output logic [SP_W-1:0]   out_stack_pointer,
  output logic [ST_W-1:0]   out_status
);

  // instruction latch
  opcode_t           op_r;
  logic [WORD_W-1:0] imm_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [WORD_W-1:0] w_r [3];

  // architectural state
  logic [WORD_W-1:0] acc_r;
  logic [PC_W-1:0]   pc_r;
  logic [SP_W-1:0]   sp_r, fb_r;
  logic              halted_r, started_r;
  status_t           cause_r;

  logic [WORD_W-1:0] mem [DATA_WORDS];
  logic [WORD_W-1:0] mem_q;
  logic [SP_W-1:0]   clr_cnt_r;

  logic              out_valid_r;
  logic [PC_W-1:0]   out_pc_r;
  logic [WORD_W-1:0] out_acc_r;
  logic [SP_W-1:0]   out_sp_r;
  status_t           out_st_r;

  // ---------------- decode / pre-access checks ----------------
  logic              is_alu, is_div, is_mul, sp_empty;
  logic [WORD_W-1:0] arg_idx;
  logic [SP_W+1:0]   call_room;
  logic              pre_err;
  logic [1:0]        n_reads, n_writes;

  assign is_alu    = (op_r >= OP_OR) && (op_r <= OP_MOD);
  assign is_div    = (op_r == OP_DIV) || (op_r == OP_MOD);
  assign is_mul    = (op_r == OP_MUL);
  assign sp_empty  = (sp_r >= SP_W'(DATA_WORDS));
  assign arg_idx   = imm_r + WORD_W'(fb_r) + WORD_W'(FRAME_WORDS);
  assign call_room = {2'b00, sp_r} - (SP_W+2)'(FRAME_WORDS) - (SP_W+2)'(cnt_r);

  always_comb begin
    pre_err  = 1'b0;
    n_reads  = 2'd0;
    n_writes = 2'd0;
    if (op_r == OP_LDC || op_r == OP_LDI) begin
      pre_err = sp_empty;
      n_reads = 2'd2;
    end else if (op_r == OP_POP || is_alu) begin
      pre_err = sp_empty;
      n_reads = 2'd1;
    end else if (op_r == OP_PUSH) begin
      pre_err  = (sp_r == '0);
      n_writes = 2'd1;
    end else if (op_r == OP_CALL) begin
      pre_err  = call_room[SP_W+1];
      n_writes = 2'd3;
    end else if (op_r == OP_RET) begin
      pre_err = (fb_r > SP_W'(DATA_WORDS - FRAME_WORDS));
      n_reads = 2'd3;
    end else if (op_r == OP_LDARG) begin
      pre_err = |arg_idx[WORD_W-1:AW];
      n_reads = 2'd1;
    end
  end

  // ---------------- memory port ----------------
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [SP_W-1:0]   call_slot;

  assign call_slot = sp_r - SP_W'(1) - SP_W'(cmd.phase);

  always_comb begin
    rd_addr = sp_r[AW-1:0];
    if (op_r == OP_RET) begin
      rd_addr = fb_r[AW-1:0] + AW'(cmd.phase);
    end else if (op_r == OP_LDARG) begin
      rd_addr = arg_idx[AW-1:0];
    end else if (cmd.phase != 2'd0 && op_r == OP_LDI) begin
      rd_addr = w_r[0][AW-1:0];
    end else if (cmd.phase != 2'd0 && op_r == OP_LDC) begin
      rd_addr = w_r[0][AW+2:3];
    end
  end

  always_comb begin
    wr_addr = call_slot[AW-1:0];
    wr_data = acc_r;
    if (op_r == OP_CALL) begin
      unique case (cmd.phase)
        2'd0:    wr_data = WORD_W'(cnt_r);
        2'd1:    wr_data = WORD_W'(fb_r);
        default: wr_data = WORD_W'(pc_r + PC_W'(FRAME_WORDS));
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_cnt_r[AW-1:0]] <= '0;
    end else if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + SP_W'(1);
    end
  end

  // ---------------- multiply / divide ----------------
  logic              md_done;
  logic [WORD_W-1:0] md_prod, md_quo, md_rem;
  logic [WORD_W-1:0] mag_acc, mag_q;

  assign mag_acc = acc_r[WORD_W-1] ? (WORD_W'(0) - acc_r) : acc_r;
  assign mag_q   = mem_q[WORD_W-1] ? (WORD_W'(0) - mem_q) : mem_q;

  sme_md u_md (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.md_start),
    .is_mul (is_mul),
    .a_in   (is_mul ? acc_r : mag_q),
    .b_in   (is_mul ? mem_q : mag_acc),
    .done   (md_done),
    .prod   (md_prod),
    .quo    (md_quo),
    .rem    (md_rem)
  );

  // ---------------- final evaluation ----------------
  logic [WORD_W-1:0] b_op, alu_res, ldc_byte;
  logic [5:0]        shamt;
  status_t           err;
  logic [WORD_W-1:0] acc_n;
  logic [PC_W-1:0]   pc_n, pc_1, pc_2;
  logic [SP_W-1:0]   sp_n, fb_n, ret_room;

  assign b_op     = w_r[0];
  assign shamt    = b_op[5:0];
  assign pc_1     = pc_r + PC_W'(1);
  assign pc_2     = pc_r + PC_W'(2);
  assign ldc_byte = WORD_W'($signed(w_r[1][{w_r[0][2:0], 3'b000} +: 8]));
  assign ret_room = SP_W'(DATA_WORDS - FRAME_WORDS) - fb_r;

  always_comb begin
    unique case (op_r)
      OP_OR:   alu_res = acc_r | b_op;
      OP_AND:  alu_res = acc_r & b_op;
      OP_EQ:   alu_res = WORD_W'(acc_r == b_op);
      OP_NE:   alu_res = WORD_W'(acc_r != b_op);
      OP_GT:   alu_res = WORD_W'($signed(b_op) < $signed(acc_r));
      OP_GE:   alu_res = WORD_W'(!($signed(acc_r) < $signed(b_op)));
      OP_LT:   alu_res = WORD_W'($signed(acc_r) < $signed(b_op));
      OP_LE:   alu_res = WORD_W'(!($signed(b_op) < $signed(acc_r)));
      OP_SHR:  alu_res = WORD_W'($signed(acc_r) >>> shamt);
      OP_SHL:  alu_res = acc_r << shamt;
      OP_ADD:  alu_res = acc_r + b_op;
      OP_SUB:  alu_res = acc_r - b_op;
      OP_MUL:  alu_res = md_prod;
      OP_DIV:  alu_res = (acc_r[WORD_W-1] ^ b_op[WORD_W-1]) ? (WORD_W'(0) - md_quo) : md_quo;
      default: alu_res = acc_r[WORD_W-1] ? (WORD_W'(0) - md_rem) : md_rem;
    endcase
  end

  always_comb begin
    err   = ST_RUN;
    acc_n = acc_r;
    pc_n  = pc_1;
    sp_n  = sp_r;
    fb_n  = fb_r;
    if (pre_err) begin
      err = ST_STACK;
    end else if (op_r > OP_EXIT) begin
      err = ST_BADOP;
    end else if (op_r == OP_CONST) begin
      acc_n = imm_r;
      pc_n  = pc_2;
    end else if (op_r == OP_LDI) begin
      if (|w_r[0][WORD_W-1:AW]) err = ST_STACK;
      acc_n = w_r[1];
      sp_n  = sp_r + SP_W'(1);
    end else if (op_r == OP_LDC) begin
      if (|w_r[0][WORD_W-1:AW+3]) err = ST_STACK;
      acc_n = ldc_byte;
      sp_n  = sp_r + SP_W'(1);
    end else if (op_r == OP_PUSH) begin
      sp_n = sp_r - SP_W'(1);
    end else if (op_r == OP_POP) begin
      acc_n = w_r[0];
      sp_n  = sp_r + SP_W'(1);
    end else if (op_r == OP_JMP) begin
      pc_n = imm_r[PC_W-1:0];
    end else if (op_r == OP_JZ || op_r == OP_JNZ) begin
      pc_n = ((acc_r == '0) == (op_r == OP_JZ)) ? imm_r[PC_W-1:0] : pc_2;
    end else if (op_r == OP_CALL) begin
      fb_n = sp_r - SP_W'(FRAME_WORDS);
      sp_n = call_room[SP_W-1:0];
      pc_n = imm_r[PC_W-1:0];
    end else if (op_r == OP_RET) begin
      if (w_r[1] > WORD_W'(DATA_WORDS) || w_r[2] > WORD_W'(ret_room)) err = ST_STACK;
      sp_n = fb_r + SP_W'(FRAME_WORDS) + w_r[2][SP_W-1:0];
      fb_n = w_r[1][SP_W-1:0];
      pc_n = w_r[0][PC_W-1:0];
    end else if (op_r == OP_LDARG) begin
      acc_n = w_r[0];
      pc_n  = pc_2;
    end else if (is_alu) begin
      if (is_div && b_op == '0) err = ST_DIVZ;
      acc_n = alu_res;
      sp_n  = sp_r + SP_W'(1);
    end
  end

  // ---------------- state registers ----------------
  always_ff @(posedge clk) begin
    if (cmd.load_instr) begin
      op_r  <= in_command;
      imm_r <= in_immediate;
      cnt_r <= in_arg_count;
    end
    if (cmd.cap_en) begin
      w_r[cmd.phase] <= mem_q;
    end
  end

  // the entry setting only matters until the first instruction runs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      pc_r      <= '0;
      sp_r      <= SP_W'(DATA_WORDS);
      fb_r      <= SP_W'(DATA_WORDS);
      halted_r  <= 1'b0;
      started_r <= 1'b0;
      cause_r   <= ST_RUN;
    end else if (cmd.commit) begin
      if (!halted_r) begin
        started_r <= 1'b1;
        if (err != ST_RUN) begin
          halted_r <= 1'b1;
          cause_r  <= err;
        end else begin
          acc_r <= acc_n;
          pc_r  <= pc_n;
          sp_r  <= sp_n;
          fb_r  <= fb_n;
          if (op_r == OP_EXIT) begin
            halted_r <= 1'b1;
            cause_r  <= ST_EXIT;
          end
        end
      end
    end else if (cfg_we) begin
      if (!started_r) pc_r <= cfg_data;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (halted_r) begin
        out_pc_r  <= pc_r;
        out_acc_r <= acc_r;
        out_sp_r  <= sp_r;
        out_st_r  <= cause_r;
      end else if (err != ST_RUN) begin
        out_pc_r  <= pc_r;
        out_acc_r <= acc_r;
        out_sp_r  <= sp_r;
        out_st_r  <= err;
      end else begin
        out_pc_r  <= pc_n;
        out_acc_r <= acc_n;
        out_sp_r  <= sp_n;
        out_st_r  <= (op_r == OP_EXIT) ? ST_EXIT : ST_RUN;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_next_pc       = out_pc_r;
  assign out_accumulator   = out_acc_r;
  assign out_stack_pointer = out_sp_r;
  assign out_status        = out_st_r;

  always_comb begin
    stat.clr_done = clr_cnt_r[SP_W-1];
    stat.halted   = halted_r;
    stat.pre_err  = pre_err || (op_r > OP_EXIT);
    stat.n_reads  = n_reads;
    stat.n_writes = n_writes;
    stat.need_md  = is_mul || (is_div && mem_q != '0);
    stat.md_done  = md_done;
    stat.out_free = !out_valid_r || out_ready;
  end

endmodule

// File: rtl/sme_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sme_ctrl - execute sequencer
// One-hot FSM: memory clear, accept, check, read/capture, mul/div, write, commit.
// ----------------------------------------------------------------------------
module sme_ctrl import sme_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_CLR  = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_CHK  = 8'b0000_0100,
    S_RD   = 8'b0000_1000,
    S_CAP  = 8'b0001_0000,
    S_MD   = 8'b0010_0000,
    S_WR   = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [2:0] phase_inc;

  assign phase_inc = {1'b0, phase_r} + 3'd1;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.phase = phase_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = !stat.clr_done;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready       = 1'b1;
        cmd.load_instr = in_valid;
        phase_nxt      = 2'd0;
        if (in_valid) state_nxt = S_CHK;
      end
      S_CHK: begin
        if (stat.halted || stat.pre_err)  state_nxt = S_FIN;
        else if (stat.n_writes != 2'd0)   state_nxt = S_WR;
        else if (stat.n_reads != 2'd0)    state_nxt = S_RD;
        else                              state_nxt = S_FIN;
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_CAP;
      end
      S_CAP: begin
        cmd.cap_en = 1'b1;
        if (phase_inc < {1'b0, stat.n_reads}) begin
          phase_nxt = phase_inc[1:0];
          state_nxt = S_RD;
        end else if (stat.need_md) begin
          cmd.md_start = 1'b1;
          state_nxt    = S_MD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_MD: begin
        if (stat.md_done) state_nxt = S_FIN;
      end
      S_WR: begin
        cmd.wr_en = 1'b1;
        if (phase_inc == {1'b0, stat.n_writes}) state_nxt = S_FIN;
        else                                     phase_nxt = phase_inc[1:0];
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      phase_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

// File: rtl/stack_machine_execute_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_execute_unit_top - bytecode execute unit
// Runs one accumulator/stack instruction per input transfer.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one instruction per transfer (command, immediate, arg_count).
//   out_ch : one result per instruction (next_pc, accumulator, stack_pointer,
//            status), held in an output register until the sink takes it.
//   cfg_we/cfg_data : entry pc; loads the pc until the first instruction runs.
// Execution time depends on the instruction, set by the single-port data
// memory with registered read data and the bit-serial multiply/divide unit:
// const, jumps, nop, exit, pre-access faults and halted runs skip memory;
// push and call write memory; pop/ALU/ldarg, ldi/ldc and ret read it;
// mul and div/mod with a nonzero divisor also run the multiply/divide unit.
// One instruction is in flight at a time; the next transfer is taken as soon
// as the result has been written to the output register.
// Reset: synchronous, active low. After reset the data memory is cleared,
// one word per cycle, all 1024 words; in_ch.ready stays low meanwhile.
// A stalled sink holds the result; a finished instruction waits for the
// output register to free up before it commits.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit_top import sme_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  sme_in_if.sink          in_ch,
  sme_out_if.source       out_ch,
  input  logic            cfg_we,
  input  logic [PC_W-1:0] cfg_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  sme_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sme_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_command        (in_ch.command),
    .in_immediate      (in_ch.immediate),
    .in_arg_count      (in_ch.arg_count),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_next_pc       (out_ch.next_pc),
    .out_accumulator   (out_ch.accumulator),
    .out_stack_pointer (out_ch.stack_pointer),
    .out_status        (out_ch.status)
  );

endmodule

// File: rtl/sme_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sme_checker - port-level checks
// Results against accepted instructions, status and stack-pointer range, halt behavior, stall hold.
// ----------------------------------------------------------------------------
module sme_checker import sme_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [PC_W-1:0]   out_next_pc,
  input logic [WORD_W-1:0] out_accumulator,
  input logic [SP_W-1:0]   out_stack_pointer,
  input logic [ST_W-1:0]   out_status
);

  logic    in_xfer, out_xfer;
  logic [1:0] pend_r;
  logic    halt_r;
  status_t halt_st_r;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= '0;
      halt_r    <= 1'b0;
      halt_st_r <= ST_RUN;
    end else begin
      pend_r <= pend_r + 2'(in_xfer) - 2'(out_xfer);
      if (out_xfer && out_status != ST_RUN && !halt_r) begin
        halt_r    <= 1'b1;
        halt_st_r <= out_status;
      end
    end
  end

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without an outstanding instruction");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_STACK && out_stack_pointer <= SP_W'(DATA_WORDS)))
    else $error("status or stack pointer out of range");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && halt_r |-> out_status == halt_st_r)
    else $error("status changed after halt");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_pc)
      && $stable(out_accumulator) && $stable(out_stack_pointer) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind stack_machine_execute_unit_top sme_checker u_sme_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_next_pc       (out_ch.next_pc),
  .out_accumulator   (out_ch.accumulator),
  .out_stack_pointer (out_ch.stack_pointer),
  .out_status        (out_ch.status)
);
